@@ rtl/astl_pkg.sv @@
// Shared types, codes and the character-to-prime map for the anagram signature lookup.
package astl_pkg;

  // Transaction kinds on the input port.
  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_CHAR  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_CMP,
    ST_FINISH
  } state_t;

  // Table read address selection.
  typedef enum logic [1:0] {
    RD_MID,
    RD_UP,
    RD_DOWN
  } rd_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;
    rd_sel_t rd_sel;
    logic    narrow;
    logic    hit;
    logic    up_take;
    logic    dn_take;
    logic    emit_miss;
    logic    emit_final;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic query_end;
    logic range_open;
    logic sig_eq;
    logic up_ok;
    logic dn_ok;
  } status_t;

  localparam logic [6:0] LETTER_PRIMES [26] = '{
    7'd2,  7'd3,  7'd5,  7'd7,  7'd11, 7'd13, 7'd17, 7'd19, 7'd23,
    7'd29, 7'd31, 7'd37, 7'd37, 7'd41, 7'd43, 7'd47, 7'd53, 7'd59,
    7'd61, 7'd67, 7'd71, 7'd73, 7'd79, 7'd83, 7'd89, 7'd97
  };

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_CASE    = 8'h20;

  // Maps a raw byte to its prime; letters are case folded, unmapped bytes give zero.
  function automatic logic [6:0] char_prime(input logic [7:0] code);
    logic [7:0] c;
    logic [7:0] off;
    logic [6:0] p;
    c = code;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      c = c + CH_CASE;
    end
    off = c - CH_LOWER_A;
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      p = LETTER_PRIMES[off[4:0]];
    end else begin
      case (c)
        8'h20:   p = 7'd101;
        8'h2D:   p = 7'd103;
        8'h2E:   p = 7'd107;
        8'h27:   p = 7'd109;
        8'h3A:   p = 7'd113;
        8'h32:   p = 7'd127;
        default: p = 7'd0;
      endcase
    end
    return p;
  endfunction

endpackage

@@ rtl/astl_ctrl.sv @@
// Controller state machine that sequences table loads, queries, the search and the match scan.
module astl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  astl_pkg::status_t status,
  output logic             busy,
  output astl_pkg::cmd_t   cmd
);

  astl_pkg::state_t state;
  astl_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= astl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      astl_pkg::ST_IDLE: begin
        if (start && status.query_end) begin
          state_next = astl_pkg::ST_PROBE;
        end
      end
      astl_pkg::ST_PROBE: begin
        state_next = status.range_open ? astl_pkg::ST_CMP : astl_pkg::ST_IDLE;
      end
      astl_pkg::ST_CMP: begin
        state_next = status.sig_eq ? astl_pkg::ST_UP_RD : astl_pkg::ST_PROBE;
      end
      astl_pkg::ST_UP_RD: begin
        state_next = status.up_ok ? astl_pkg::ST_UP_CMP : astl_pkg::ST_DN_RD;
      end
      astl_pkg::ST_UP_CMP: begin
        state_next = status.sig_eq ? astl_pkg::ST_UP_RD : astl_pkg::ST_DN_RD;
      end
      astl_pkg::ST_DN_RD: begin
        state_next = status.dn_ok ? astl_pkg::ST_DN_CMP : astl_pkg::ST_FINISH;
      end
      astl_pkg::ST_DN_CMP: begin
        state_next = status.sig_eq ? astl_pkg::ST_DN_RD : astl_pkg::ST_FINISH;
      end
      astl_pkg::ST_FINISH: begin
        state_next = astl_pkg::ST_IDLE;
      end
      default: begin
        state_next = astl_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd  = '0;
    cmd.rd_sel = astl_pkg::RD_MID;
    busy = (state != astl_pkg::ST_IDLE);
    case (state)
      astl_pkg::ST_IDLE: begin
        cmd.accept = start;
      end
      astl_pkg::ST_PROBE: begin
        cmd.emit_miss = !status.range_open;
      end
      astl_pkg::ST_CMP: begin
        cmd.hit    = status.sig_eq;
        cmd.narrow = !status.sig_eq;
      end
      astl_pkg::ST_UP_RD: begin
        cmd.rd_sel = astl_pkg::RD_UP;
      end
      astl_pkg::ST_UP_CMP: begin
        cmd.up_take = status.sig_eq;
      end
      astl_pkg::ST_DN_RD: begin
        cmd.rd_sel = astl_pkg::RD_DOWN;
      end
      astl_pkg::ST_DN_CMP: begin
        cmd.dn_take = status.sig_eq;
      end
      astl_pkg::ST_FINISH: begin
        cmd.emit_final = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ rtl/astl_datapath.sv @@
// Datapath: signature product, entry table memory, search bounds, match scan and result registers.
module astl_datapath #(
  parameter int TABLE_DEPTH = 4096,
  parameter int MAX_MATCHES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  astl_pkg::cmd_t    cmd,
  output astl_pkg::status_t status,
  input  logic [1:0]        kind,
  input  logic [63:0]       signature,
  input  logic [15:0]       word_id,
  input  logic [7:0]        char_code,
  input  logic              last_char,
  output logic              strobe,
  output logic [15:0]       match_id,
  output logic              found,
  output logic              last
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int NW = $clog2(MAX_MATCHES + 1);

  // Table storage.
  logic [63:0] sig_mem [TABLE_DEPTH];
  logic [15:0] id_mem  [TABLE_DEPTH];
  logic [63:0] rd_sig;
  logic [15:0] rd_id;
  logic [IW-1:0] rd_addr;

  logic [CW-1:0] entry_count;
  logic [63:0]   running_product;
  logic [63:0]   key;
  logic [CW-1:0] lo;
  logic [CW-1:0] hiex;
  logic [CW-1:0] mid;
  logic [CW-1:0] up;
  logic [CW-1:0] dnp1;
  logic [NW-1:0] n;
  logic [15:0]   pend_id;

  logic [CW-1:0] span;
  logic [CW-1:0] mid_w;
  logic [CW-1:0] dn_addr;
  logic [70:0]   prod_full;
  logic          is_load;
  logic          is_char;
  logic          is_clear;

  assign is_load  = (kind == astl_pkg::KIND_LOAD);
  assign is_char  = (kind == astl_pkg::KIND_CHAR);
  assign is_clear = (kind == astl_pkg::KIND_CLEAR);
  assign prod_full = running_product * astl_pkg::char_prime(char_code);

  // Midpoint of the open search range, lo + (hi - lo) / 2 with hi = hiex - 1.
  assign span    = hiex - lo - CW'(1);
  assign mid_w   = lo + (span >> 1);
  assign dn_addr = dnp1 - CW'(1);

  // Read address selection.
  always_comb begin
    case (cmd.rd_sel)
      astl_pkg::RD_UP:   rd_addr = up[IW-1:0];
      astl_pkg::RD_DOWN: rd_addr = dn_addr[IW-1:0];
      default:           rd_addr = mid_w[IW-1:0];
    endcase
  end

  // Memory write on a load transaction and registered read every cycle.
  always_ff @(posedge clk) begin
    if (cmd.accept && is_load && entry_count < CW'(TABLE_DEPTH)) begin
      sig_mem[entry_count[IW-1:0]] <= signature;
      id_mem[entry_count[IW-1:0]]  <= word_id;
    end
    rd_sig <= sig_mem[rd_addr];
    rd_id  <= id_mem[rd_addr];
  end

  // Entry count and running product.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count     <= '0;
      running_product <= 64'd1;
    end else if (cmd.accept) begin
      if (is_load && entry_count < CW'(TABLE_DEPTH)) begin
        entry_count <= entry_count + CW'(1);
      end
      if (is_clear) begin
        entry_count <= '0;
      end
      if (is_char) begin
        running_product <= last_char ? 64'd1 : prod_full[63:0];
      end
    end
  end

  // Search key, bounds and match scan pointers.
  always_ff @(posedge clk) begin
    if (cmd.accept && is_char && last_char) begin
      key  <= prod_full[63:0];
      lo   <= '0;
      hiex <= entry_count;
    end
    if (cmd.rd_sel == astl_pkg::RD_MID) begin
      mid <= mid_w;
    end
    if (cmd.narrow) begin
      if (rd_sig < key) begin
        lo <= mid + CW'(1);
      end else begin
        hiex <= mid;
      end
    end
    if (cmd.hit) begin
      pend_id <= rd_id;
      n       <= NW'(1);
      up      <= mid + CW'(1);
      dnp1    <= mid;
    end
    if (cmd.up_take) begin
      pend_id <= rd_id;
      n       <= n + NW'(1);
      up      <= up + CW'(1);
    end
    if (cmd.dn_take) begin
      pend_id <= rd_id;
      n       <= n + NW'(1);
      dnp1    <= dn_addr;
    end
  end

  // Result registers: a match is held back one step so that the final one carries last.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_miss | cmd.emit_final | cmd.up_take | cmd.dn_take;
    end
    if (cmd.emit_miss) begin
      match_id <= 16'd0;
      found    <= 1'b0;
      last     <= 1'b1;
    end else begin
      match_id <= pend_id;
      found    <= 1'b1;
      last     <= cmd.emit_final;
    end
  end

  // Status back to the controller.
  always_comb begin
    status.query_end  = is_char && last_char;
    status.range_open = (lo < hiex);
    status.sig_eq     = (rd_sig == key);
    status.up_ok      = (n < NW'(MAX_MATCHES)) && (up < entry_count);
    status.dn_ok      = (n < NW'(MAX_MATCHES)) && (dnp1 != '0);
  end

endmodule

@@ rtl/anagram_signature_table_lookup.sv @@
// Top level of the anagram signature table lookup: controller and datapath.
//
// A transaction is taken when start is high and busy is low. Table loads, clears and query
// characters other than the last keep the controller idle; the next transaction may follow in
// the very next cycle. Each character folds into the running product through one small
// multiplier. The last character starts a binary search of the table, read through a single
// port with registered data, so each probe passes through a probe state that issues the read
// and a compare state, and a miss ends in one more probe state that finds the range empty. A
// miss gives its not-found result at the end of the search. A hit then scans equal neighbours
// above and below, each match through a read state and a compare state, and a finish state
// delivers the final result, for at most MAX_MATCHES results. Results appear as one-cycle
// pulses on strobe and cannot be held off, so the receiver must take every pulse; busy stays
// high until the last result of a query has been issued.
module anagram_signature_table_lookup #(
  parameter int TABLE_DEPTH = 4096,
  parameter int MAX_MATCHES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [63:0] signature,
  input  logic [15:0] word_id,
  input  logic [7:0]  char_code,
  input  logic        last_char,
  output logic        strobe,
  output logic [15:0] match_id,
  output logic        found,
  output logic        last
);

  astl_pkg::cmd_t    cmd;
  astl_pkg::status_t status;

  // Sequencing.
  astl_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  // Storage and arithmetic.
  astl_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_MATCHES (MAX_MATCHES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .kind      (kind),
    .signature (signature),
    .word_id   (word_id),
    .char_code (char_code),
    .last_char (last_char),
    .strobe    (strobe),
    .match_id  (match_id),
    .found     (found),
    .last      (last)
  );

endmodule

@@ test/anagram_match_checker.sv @@
// Checker for the anagram signature lookup: watches both channels, predicts and compares.
module anagram_match_checker
  import astl_pkg::*;
#(
  parameter int TABLE_DEPTH = 4096,
  parameter int MAX_MATCHES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  kind,
  input  logic [63:0] signature,
  input  logic [15:0] word_id,
  input  logic [7:0]  char_code,
  input  logic        last_char,
  input  logic        strobe,
  input  logic [15:0] match_id,
  input  logic        found,
  input  logic        last,
  output int          fail_count,
  output int          pending,
  output int          query_count,
  output int          result_count
);

  typedef struct packed {
    logic [15:0] id;
    logic        found;
    logic        last;
  } lookup_result_t;

  // Our own copy of the table, the entry count and the running product.
  logic [63:0]    sig_table [TABLE_DEPTH];
  logic [15:0]    id_table  [TABLE_DEPTH];
  int             table_fill;
  logic [63:0]    product;
  lookup_result_t expected_results [$];

  // Prime for one query byte after case folding; bytes outside the map give zero.
  function automatic logic [6:0] fold_prime(input logic [7:0] b);
    logic [7:0] c;
    logic [6:0] p;
    c = b;
    if (c >= 8'h41 && c <= 8'h5A) begin
      c = c + 8'd32;
    end
    case (c)
      8'h61: p = 7'd2;   8'h62: p = 7'd3;   8'h63: p = 7'd5;   8'h64: p = 7'd7;
      8'h65: p = 7'd11;  8'h66: p = 7'd13;  8'h67: p = 7'd17;  8'h68: p = 7'd19;
      8'h69: p = 7'd23;  8'h6A: p = 7'd29;  8'h6B: p = 7'd31;  8'h6C: p = 7'd37;
      8'h6D: p = 7'd37;  8'h6E: p = 7'd41;  8'h6F: p = 7'd43;  8'h70: p = 7'd47;
      8'h71: p = 7'd53;  8'h72: p = 7'd59;  8'h73: p = 7'd61;  8'h74: p = 7'd67;
      8'h75: p = 7'd71;  8'h76: p = 7'd73;  8'h77: p = 7'd79;  8'h78: p = 7'd83;
      8'h79: p = 7'd89;  8'h7A: p = 7'd97;
      8'h20: p = 7'd101; 8'h2D: p = 7'd103; 8'h2E: p = 7'd107; 8'h27: p = 7'd109;
      8'h3A: p = 7'd113; 8'h32: p = 7'd127;
      default: p = 7'd0;
    endcase
    return p;
  endfunction

  // Binary search for the key; the first hit, then equal entries above, then below.
  function automatic void predict_lookup(input logic [63:0] key);
    int lo, hi, mid, up, dn;
    bit hit;
    logic [15:0] ids [$];
    lookup_result_t r;
    lo = 0;
    hi = table_fill - 1;
    hit = 1'b0;
    while (lo <= hi && !hit) begin
      mid = lo + (hi - lo) / 2;
      if (sig_table[mid] == key) begin
        hit = 1'b1;
        ids = {ids, id_table[mid]};
        up = mid + 1;
        dn = mid - 1;
        while (ids.size() < MAX_MATCHES && up < table_fill && sig_table[up] == key) begin
          ids = {ids, id_table[up]};
          up++;
        end
        while (ids.size() < MAX_MATCHES && dn >= 0 && sig_table[dn] == key) begin
          ids = {ids, id_table[dn]};
          dn--;
        end
      end else if (sig_table[mid] < key) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    if (hit) begin
      for (int i = 0; i < ids.size(); i++) begin
        r.id = ids[i];
        r.found = 1'b1;
        r.last = (i == ids.size() - 1);
        expected_results = {expected_results, r};
      end
    end else begin
      r.id = 16'd0;
      r.found = 1'b0;
      r.last = 1'b1;
      expected_results = {expected_results, r};
    end
  endfunction

  // Results are checked before a new transaction is folded in at the same edge.
  always @(posedge clk) begin : monitor
    lookup_result_t exp_r;
    if (rst) begin
      table_fill = 0;
      product = 64'd1;
      expected_results.delete();
      fail_count = 0;
      query_count = 0;
      result_count = 0;
    end else begin
      if (strobe) begin
        result_count++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual id %h found %b last %b",
                   $time, match_id, found, last);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (match_id !== exp_r.id) begin
            $display("%0t: match_id mismatch: expected %h, actual %h", $time, exp_r.id, match_id);
            fail_count++;
          end
          if (found !== exp_r.found) begin
            $display("%0t: found mismatch: expected %b, actual %b", $time, exp_r.found, found);
            fail_count++;
          end
          if (last !== exp_r.last) begin
            $display("%0t: last mismatch: expected %b, actual %b", $time, exp_r.last, last);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        case (kind)
          KIND_LOAD: begin
            if (table_fill < TABLE_DEPTH) begin
              sig_table[table_fill] = signature;
              id_table[table_fill] = word_id;
              table_fill++;
            end
          end
          KIND_CLEAR: begin
            table_fill = 0;
          end
          KIND_CHAR: begin
            product = product * fold_prime(char_code);
            if (last_char) begin
              query_count++;
              predict_lookup(product);
              product = 64'd1;
            end
          end
          default: begin
          end
        endcase
      end
    end
    pending = expected_results.size();
  end

endmodule

@@ test/anagram_signature_table_lookup_test.sv @@
// Testbench top for the anagram signature lookup: drives transactions and gives the verdict.
module anagram_signature_table_lookup_test;
  import astl_pkg::*;

  localparam int TABLE_DEPTH   = 4096;
  localparam int MAX_MATCHES   = 64;
  localparam int ITEM_TARGET   = 480;
  localparam int WORD_MAX      = 12;
  localparam int VOCAB_MAX     = 6;
  localparam int ROUND_MAX     = 128;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 200;

  typedef struct packed {
    logic [7:0] code;
    logic [6:0] prime;
  } pool_char_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  kind;
  logic [63:0] signature;
  logic [15:0] word_id;
  logic [7:0]  char_code;
  logic        last_char;
  logic        strobe;
  logic [15:0] match_id;
  logic        found;
  logic        last;

  int fail_count;
  int pending;
  int query_count;
  int result_count;
  int items_sent = 0;
  int cycle_count = 0;
  bit steady = 1'b0;

  logic [7:0] word_buf [WORD_MAX];
  int         word_len;

  anagram_signature_table_lookup #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .MAX_MATCHES(MAX_MATCHES)
  ) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .signature(signature), .word_id(word_id), .char_code(char_code),
    .last_char(last_char), .strobe(strobe), .match_id(match_id),
    .found(found), .last(last)
  );

  anagram_match_checker #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .MAX_MATCHES(MAX_MATCHES)
  ) lookup_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .signature(signature), .word_id(word_id), .char_code(char_code),
    .last_char(last_char), .strobe(strobe), .match_id(match_id),
    .found(found), .last(last), .fail_count(fail_count), .pending(pending),
    .query_count(query_count), .result_count(result_count)
  );

  always #1 clk = ~clk;

  // Cycle counter with a hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count, pending);
      $display("anagram_signature_table_lookup verification failed");
      $finish;
    end
  end

  // Characters whose primes the stimulus knows, so that hits can be planned.
  function automatic pool_char_t pool_char(input int idx);
    case (idx)
      0:  return {8'h61, 7'd2};
      1:  return {8'h41, 7'd2};
      2:  return {8'h62, 7'd3};
      3:  return {8'h42, 7'd3};
      4:  return {8'h6C, 7'd37};
      5:  return {8'h4C, 7'd37};
      6:  return {8'h6D, 7'd37};
      7:  return {8'h4D, 7'd37};
      8:  return {8'h7A, 7'd97};
      9:  return {8'h5A, 7'd97};
      10: return {8'h20, 7'd101};
      11: return {8'h2D, 7'd103};
      12: return {8'h2E, 7'd107};
      13: return {8'h27, 7'd109};
      14: return {8'h3A, 7'd113};
      default: return {8'h32, 7'd127};
    endcase
  endfunction

  // Bytes that map to no prime, including those next to the letter ranges.
  function automatic logic [7:0] unmapped_char(input int idx);
    case (idx)
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7B;
      4: return 8'h40;
      5: return 8'h5B;
      6: return 8'h60;
      default: return 8'h31;
    endcase
  endfunction

  // Mostly no gap or a short one, now and then a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // One transaction: optional idle gap, then start held until busy is low at an edge.
  task automatic issue(input kind_t k, input logic [63:0] sig, input logic [15:0] id,
                       input logic [7:0] ch, input logic lc);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    kind <= k;
    signature <= sig;
    word_id <= id;
    char_code <= ch;
    last_char <= lc;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (k != KIND_NONE) items_sent++;
  endtask

  // Fields that a kind does not use carry random values.
  task automatic load_entry(input logic [63:0] sig, input logic [15:0] id);
    issue(KIND_LOAD, sig, id, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_char(input logic [7:0] ch, input logic lc);
    issue(KIND_CHAR, {$urandom, $urandom}, 16'($urandom_range(0, 65535)), ch, lc);
  endtask

  task automatic clear_table();
    issue(KIND_CLEAR, {$urandom, $urandom}, 16'($urandom_range(0, 65535)),
          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_noise();
    issue(KIND_NONE, {$urandom, $urandom}, 16'($urandom_range(0, 65535)),
          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // Sends the word buffer as a query, with an odd ignored transaction slipped in.
  task automatic send_word();
    for (int i = 0; i < word_len; i++) begin
      if ($urandom_range(0, 19) == 0) send_noise();
      send_char(word_buf[i], i == word_len - 1);
    end
  endtask

  task automatic query_text(input string s);
    word_len = s.len();
    for (int i = 0; i < word_len; i++) word_buf[i] = s[i];
    send_word();
  endtask

  // Random word from the known characters, with its signature.
  task automatic make_pool_word(input int len, output logic [63:0] sig);
    pool_char_t pc;
    sig = 64'd1;
    word_len = len;
    for (int i = 0; i < len; i++) begin
      pc = pool_char($urandom_range(0, 15));
      word_buf[i] = pc.code;
      sig = sig * pc.prime;
    end
  endtask

  // One round: maybe clear, load a table built from a vocabulary, then query it.
  task automatic run_round(input int round_no);
    logic [63:0] tab_sig [ROUND_MAX];
    logic [15:0] tab_id  [ROUND_MAX];
    logic [7:0]  vtext   [VOCAB_MAX][WORD_MAX];
    int          vlen    [VOCAB_MAX];
    logic [63:0] vsig    [VOCAB_MAX];
    logic [63:0] tmp_sig;
    logic [15:0] tmp_id;
    logic [7:0]  tmp_ch;
    int          tab_n, vcount, dups, nq, pick, v, j, len;
    bit          flood, shuffled;
    steady = ($urandom_range(0, 3) == 0);
    flood = (round_no == 2) || ($urandom_range(0, 9) == 0);
    shuffled = ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 5) != 0) clear_table();

    // Vocabulary words go in 1 to 3 times or not at all; a flood word goes in MAX_MATCHES + 6.
    tab_n = 0;
    vcount = $urandom_range(1, VOCAB_MAX);
    for (int w = 0; w < vcount; w++) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, WORD_MAX) : $urandom_range(1, 5);
      make_pool_word(len, vsig[w]);
      vlen[w] = word_len;
      for (int i = 0; i < word_len; i++) vtext[w][i] = word_buf[i];
      dups = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
      if (flood && w == 0) dups = MAX_MATCHES + 6;
      for (int d = 0; d < dups; d++) begin
        tab_sig[tab_n] = vsig[w];
        tab_id[tab_n] = 16'($urandom_range(0, 65535));
        tab_n++;
      end
    end

    // Unrelated fillers, and now and then the two extreme signatures.
    for (int f = $urandom_range(0, 6); f > 0; f--) begin
      tab_sig[tab_n] = {$urandom, $urandom};
      tab_id[tab_n] = 16'($urandom_range(0, 65535));
      tab_n++;
    end
    if ($urandom_range(0, 3) == 0) begin
      tab_sig[tab_n] = 64'd0;
      tab_id[tab_n] = 16'($urandom_range(0, 65535));
      tab_n++;
    end
    if ($urandom_range(0, 3) == 0) begin
      tab_sig[tab_n] = '1;
      tab_id[tab_n] = 16'($urandom_range(0, 65535));
      tab_n++;
    end

    // Ascending order unless this round tries an unsorted table.
    if (!shuffled) begin
      for (int a = 0; a < tab_n; a++) begin
        for (int b = 0; b + 1 < tab_n - a; b++) begin
          if (tab_sig[b] > tab_sig[b + 1]) begin
            tmp_sig = tab_sig[b];
            tab_sig[b] = tab_sig[b + 1];
            tab_sig[b + 1] = tmp_sig;
            tmp_id = tab_id[b];
            tab_id[b] = tab_id[b + 1];
            tab_id[b + 1] = tmp_id;
          end
        end
      end
    end
    for (int i = 0; i < tab_n; i++) begin
      if ($urandom_range(0, 29) == 0) send_noise();
      load_entry(tab_sig[i], tab_id[i]);
    end

    // Queries: mostly anagrams of the vocabulary, the rest misses, zeros and raw bytes.
    nq = $urandom_range(3, 7);
    for (int q = 0; q < nq; q++) begin
      pick = (flood && q == 0) ? 0 : $urandom_range(0, 19);
      v = (flood && q == 0) ? 0 : $urandom_range(0, vcount - 1);
      if (pick < 12 || (pick >= 15 && pick < 17)) begin
        word_len = vlen[v];
        for (int i = 0; i < word_len; i++) word_buf[i] = vtext[v][i];
        for (int i = word_len - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp_ch = word_buf[i];
          word_buf[i] = word_buf[j];
          word_buf[j] = tmp_ch;
        end
        if (pick >= 15) begin
          word_buf[$urandom_range(0, word_len - 1)] = unmapped_char($urandom_range(0, 7));
        end
      end else if (pick < 15) begin
        make_pool_word($urandom_range(1, 8), tmp_sig);
      end else begin
        word_len = $urandom_range(1, 5);
        for (int i = 0; i < word_len; i++) word_buf[i] = 8'($urandom_range(0, 255));
      end
      send_word();
    end
  endtask

  initial begin
    int round_no;
    rst <= 1'b1;
    start <= 1'b0;
    kind <= KIND_NONE;
    signature <= '0;
    word_id <= '0;
    char_code <= '0;
    last_char <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, extreme loads, duplicates, zero product, l and m sharing a prime.
    steady = 1'b0;
    query_text("a");
    load_entry(64'd0, 16'h0000);
    load_entry(64'd2, 16'hFFFF);
    load_entry(64'd2, 16'h1234);
    load_entry(64'd1369, 16'h5A5A);
    load_entry('1, 16'h8001);
    query_text("A");
    word_buf[0] = 8'hFF;
    word_len = 1;
    send_word();
    query_text("Lm");
    query_text("mL");
    query_text("b");
    send_noise();
    query_text(" -.':2");
    // The running product survives a clear and a load in the middle of a word.
    send_char(8'h62, 1'b0);
    clear_table();
    load_entry(64'd15, 16'h00F0);
    send_char(8'h63, 1'b1);
    clear_table();
    query_text("z");

    // Random rounds until the item budget is spent.
    round_no = 0;
    while (items_sent < ITEM_TARGET) begin
      run_round(round_no);
      round_no++;
    end

    // A few closing queries against the last table.
    steady = 1'b0;
    query_text("a");
    query_text("bA");
    word_buf[0] = 8'h00;
    word_len = 1;
    send_word();
    query_text("z");
    query_text("Lm");
    start <= 1'b0;

    // Drain the outstanding results, then allow time for any stray one.
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d transactions; %0d queries returned %0d results.",
             items_sent, query_count, result_count);
    $display("Covered empty, sorted and unsorted tables, capped match lists and wrapping.");
    if (fail_count == 0 && pending == 0) begin
      $display("anagram_signature_table_lookup verification clean");
    end else begin
      $display("anagram_signature_table_lookup verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/astl_pkg.sv
rtl/astl_ctrl.sv
rtl/astl_datapath.sv
rtl/anagram_signature_table_lookup.sv
test/anagram_match_checker.sv
test/anagram_signature_table_lookup_test.sv
